[hw/rtl/smasm_pkg.sv]
`timescale 1ns / 1ps
// shared constants, codes and types of the sparse matrix add/sub/mul unit
package smasm_pkg;

    localparam int MAX_DIM_DEFAULT = 32;
    localparam int LANE_CAP        = 32;
    localparam int DATA_W          = 32;
    localparam int IDX_W           = 5;
    localparam int MODE_W          = 2;
    localparam int DIM_W           = 6;
    localparam int OP_W            = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 6;

    // request modes
    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    // operation register codes
    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION = 2'd1;

    localparam logic [DIM_W-1:0] DIMENSION_RESET = 6'd32;
    localparam logic [OP_W-1:0]  OPERATION_RESET = OP_ADD;

    // control of the matrix store
    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic rd;
    } mat_ctl_t;

endpackage

[hw/rtl/smasm_mat_store.sv]
`timescale 1ns / 1ps
// dense stores of matrices A and B, one write port and one registered read port each
module smasm_mat_store
    import smasm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT,
    localparam int DEPTH = MAX_DIM * MAX_DIM,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  mat_ctl_t          ctl,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr_a,
    input  logic [AW-1:0]     rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem_a_reg [DEPTH];
    logic [DATA_W-1:0] mem_b_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_a_reg;
    logic [DATA_W-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_a)
        begin
            mem_a_reg[wr_addr] <= wr_data;
        end
        if (ctl.rd)
        begin
            rd_data_a_reg <= mem_a_reg[rd_addr_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_b)
        begin
            mem_b_reg[wr_addr] <= wr_data;
        end
        if (ctl.rd)
        begin
            rd_data_b_reg <= mem_b_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

[hw/rtl/sparse_matrix_add_sub_mul_unit.sv]
`timescale 1ns / 1ps
// top level of the sparse matrix add/sub/mul unit: sequencer, row accumulator, output register
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------------
//  cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in       | in_valid/in_ready    | mode, row, column, value
//  out      | out_valid/out_ready  | row_out, col_out, entry_value, empty_row, last
//
//  a load request is written as it is taken; a row outside the dimension goes through ST_EMPTY
//  add/sub row: d reads of each matrix store, multiply row: d*d reads, with d the
//  active dimension; ST_ISSUE makes one read of each matrix store per cycle
//  then a scan of the row accumulator: ST_SCAN_RD steps through the columns up to the last
//  nonzero one, ST_SCAN_OUT loads each result; a stalled output holds the scan
//  no clearing pass after reset: matrix and accumulator stores hold nothing until written
//  a new request is taken as soon as the last result of a row sits in the output register
module sparse_matrix_add_sub_mul_unit
    import smasm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [MODE_W-1:0]        mode,
    input  logic [IDX_W-1:0]         row,
    input  logic [IDX_W-1:0]         column,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [IDX_W-1:0]         row_out,
    output logic [IDX_W-1:0]         col_out,
    output logic signed [DATA_W-1:0] entry_value,
    output logic                     empty_row,
    output logic                     last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_N = (MAX_DIM < LANE_CAP) ? MAX_DIM : LANE_CAP;
    localparam int JW    = (COL_N > 1) ? $clog2(COL_N) : 1;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_ISSUE    = 6'b000010,
        ST_DRAIN    = 6'b000100,
        ST_SCAN_RD  = 6'b001000,
        ST_SCAN_OUT = 6'b010000,
        ST_EMPTY    = 6'b100000
    } state_t;

    // control registers
    state_t            state_reg, state_next;
    logic [DIM_W-1:0]  dimension_reg, dimension_next;
    logic [OP_W-1:0]   operation_reg, operation_next;
    logic [JW-1:0]     j_reg, j_next;
    logic [JW-1:0]     k_reg, k_next;
    logic [JW-1:0]     sj_reg, sj_next;
    logic [JW-1:0]     dlim_reg, dlim_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [COL_N-1:0]  mask_reg, mask_next;
    logic              p1_valid_reg, p2_valid_reg;
    logic              out_valid_reg, out_valid_next;

    // pipeline payload
    logic              p1_first_reg, p1_lastk_reg;
    logic [JW-1:0]     p1_j_reg;
    logic              p2_first_reg, p2_lastk_reg;
    logic [JW-1:0]     p2_j_reg;
    logic [DATA_W-1:0] prod_reg, prod_next;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_sum;

    // row accumulator store
    logic [DATA_W-1:0] racc_mem_reg [COL_N];
    logic [DATA_W-1:0] racc_rdata_reg;
    logic              racc_rd;

    // output register payload
    logic [IDX_W-1:0]  row_out_reg;
    logic [IDX_W-1:0]  col_out_reg;
    logic [DATA_W-1:0] value_out_reg;
    logic              empty_out_reg;
    logic              last_out_reg;

    logic              out_free;
    logic              out_load;
    logic              out_empty;
    logic              out_last;
    logic              scan_last;
    logic              issue;
    logic              is_mul;
    logic [DIM_W-1:0]  dim_act;
    logic              row_active;
    logic              load_in_range;
    logic [AW-1:0]     load_addr;
    logic [AW-1:0]     row_base;
    logic [AW-1:0]     rd_addr_a;
    logic [AW-1:0]     rd_addr_b;
    logic [DATA_W-1:0] rd_data_a;
    logic [DATA_W-1:0] rd_data_b;
    mat_ctl_t          mat_ctl;

    smasm_mat_store #(
        .MAX_DIM (MAX_DIM)
    ) u_store (
        .clk       (clk),
        .ctl       (mat_ctl),
        .wr_addr   (load_addr),
        .wr_data   ($unsigned(value)),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign is_mul    = (operation_reg == OP_MUL);

    // active dimension, limited to the store and lane size
    assign dim_act       = (dimension_reg > DIM_W'(COL_N)) ? DIM_W'(COL_N) : dimension_reg;
    assign row_active    = ({1'b0, row} < dim_act);
    assign load_in_range = (32'(row) < MAX_DIM) && (32'(column) < MAX_DIM);
    assign load_addr     = AW'(row) * AW'(MAX_DIM) + AW'(column);
    assign row_base      = AW'(row_reg) * AW'(MAX_DIM);

    assign out_free  = !out_valid_reg || out_ready;
    assign scan_last = ((mask_reg & ~(COL_N'(1) << sj_reg)) == '0);
    assign acc_sum   = (p2_first_reg ? '0 : acc_reg) + prod_reg;

    always_comb
    begin
        dimension_next = dimension_reg;
        operation_next = operation_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DIMENSION: dimension_next = cfg_data;
                CFG_OPERATION: operation_next = cfg_data[OP_W-1:0];
                default: ;
            endcase
        end
    end

    // element operation on the data read from both stores
    always_comb
    begin
        unique case (operation_reg)
            OP_ADD:  prod_next = rd_data_a + rd_data_b;
            OP_SUB:  prod_next = rd_data_a - rd_data_b;
            OP_MUL:  prod_next = rd_data_a * rd_data_b;
            default: prod_next = rd_data_a + rd_data_b;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        sj_next    = sj_reg;
        dlim_next  = dlim_reg;
        row_next   = row_reg;
        mask_next  = mask_reg;
        mat_ctl    = '0;
        rd_addr_a  = row_base + AW'(j_reg);
        rd_addr_b  = row_base + AW'(j_reg);
        issue      = 1'b0;
        racc_rd    = 1'b0;
        out_load   = 1'b0;
        out_empty  = 1'b0;
        out_last   = 1'b0;

        if (p2_valid_reg && p2_lastk_reg)
        begin
            mask_next[p2_j_reg] = (acc_sum != '0);
        end

        if (is_mul)
        begin
            rd_addr_a = row_base + AW'(k_reg);
            rd_addr_b = AW'(k_reg) * AW'(MAX_DIM) + AW'(j_reg);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (mode)
                        MODE_LOAD_A:  mat_ctl.wr_a = load_in_range;
                        MODE_LOAD_B:  mat_ctl.wr_b = load_in_range;
                        MODE_COMPUTE:
                        begin
                            row_next = row;
                            if (row_active)
                            begin
                                dlim_next  = JW'(dim_act - 1'b1);
                                j_next     = '0;
                                k_next     = '0;
                                mask_next  = '0;
                                state_next = ST_ISSUE;
                            end
                            else
                            begin
                                state_next = ST_EMPTY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ISSUE:
            begin
                issue      = 1'b1;
                mat_ctl.rd = 1'b1;
                if (is_mul && (k_reg != dlim_reg))
                begin
                    k_next = JW'(k_reg + 1'b1);
                end
                else
                begin
                    k_next = '0;
                    if (j_reg == dlim_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        j_next = JW'(j_reg + 1'b1);
                    end
                end
            end
            ST_DRAIN:
            begin
                // wait for the last accumulator write before scanning
                if (!p1_valid_reg && !p2_valid_reg)
                begin
                    sj_next    = '0;
                    state_next = (mask_reg == '0) ? ST_EMPTY : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                if (mask_reg[sj_reg])
                begin
                    racc_rd    = 1'b1;
                    state_next = ST_SCAN_OUT;
                end
                else
                begin
                    sj_next = JW'(sj_reg + 1'b1);
                end
            end
            ST_SCAN_OUT:
            begin
                if (out_free)
                begin
                    out_load          = 1'b1;
                    out_last          = scan_last;
                    mask_next[sj_reg] = 1'b0;
                    if (scan_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        sj_next    = JW'(sj_reg + 1'b1);
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_empty  = 1'b1;
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dimension_reg <= DIMENSION_RESET;
            operation_reg <= OPERATION_RESET;
            j_reg         <= '0;
            k_reg         <= '0;
            sj_reg        <= '0;
            dlim_reg      <= '0;
            row_reg       <= '0;
            mask_reg      <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dimension_reg <= dimension_next;
            operation_reg <= operation_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            sj_reg        <= sj_next;
            dlim_reg      <= dlim_next;
            row_reg       <= row_next;
            mask_reg      <= mask_next;
            p1_valid_reg  <= issue;
            p2_valid_reg  <= p1_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // issue -> store read -> element op -> accumulate
    always_ff @(posedge clk)
    begin
        p1_first_reg <= is_mul ? (k_reg == '0) : 1'b1;
        p1_lastk_reg <= is_mul ? (k_reg == dlim_reg) : 1'b1;
        p1_j_reg     <= j_reg;
        p2_first_reg <= p1_first_reg;
        p2_lastk_reg <= p1_lastk_reg;
        p2_j_reg     <= p1_j_reg;
        prod_reg     <= prod_next;
        if (p2_valid_reg)
        begin
            acc_reg <= acc_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p2_valid_reg && p2_lastk_reg)
        begin
            racc_mem_reg[p2_j_reg] <= acc_sum;
        end
        if (racc_rd)
        begin
            racc_rdata_reg <= racc_mem_reg[sj_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            row_out_reg   <= row_reg;
            col_out_reg   <= out_empty ? '0 : IDX_W'(sj_reg);
            value_out_reg <= out_empty ? '0 : racc_rdata_reg;
            empty_out_reg <= out_empty;
            last_out_reg  <= out_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign row_out     = row_out_reg;
    assign col_out     = col_out_reg;
    assign entry_value = $signed(value_out_reg);
    assign empty_row   = empty_out_reg;
    assign last        = last_out_reg;

    // pipeline is empty whenever a new request can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!p1_valid_reg && !p2_valid_reg))
        else $error("compute pipeline busy while idle");

    // a result is never loaded over one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    // scan only runs while some column is still pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_RD) |-> (mask_reg != '0))
        else $error("scan with no pending column");

    // the column being emitted is one marked nonzero
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_OUT) |-> mask_reg[sj_reg])
        else $error("emitting a column not marked nonzero");

    // a non-empty result carries a nonzero value
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && !empty_out_reg |-> (value_out_reg != '0))
        else $error("zero entry emitted");

endmodule
